FILE: rtl/hexdec_pkg.sv
`default_nettype none

package hexdec_pkg;

  // Size of the downstream byte buffer; the active limit never exceeds it.
  localparam int BufferBytes = 256;

  typedef enum logic [1:0] {
    ErrNone     = 2'd0,
    ErrBadChar  = 2'd1,
    ErrOverflow = 2'd2,
    ErrOdd      = 2'd3
  } err_t;

  typedef struct packed {
    logic       is_digit;
    logic       is_sep;
    logic [3:0] value;
  } char_class_t;

endpackage

`default_nettype wire

FILE: rtl/hexdec_classify.sv
`default_nettype none

module hexdec_classify (
  input  wire logic [7:0]               ch,
  output hexdec_pkg::char_class_t       cls
);

  localparam logic [7:0] CharSpace = 8'h20;
  localparam logic [7:0] CharTab   = 8'h09;
  localparam logic [7:0] CharComma = 8'h2C;
  localparam logic [7:0] CharColon = 8'h3A;
  localparam logic [7:0] CharDash  = 8'h2D;

  always_comb begin
    cls = '0;
    case (ch) inside
      [8'h30:8'h39]: begin
        cls.is_digit = 1'b1;
        cls.value    = ch[3:0];
      end
      // 'a'..'f' and 'A'..'F' share low nibbles 1..6
      [8'h61:8'h66], [8'h41:8'h46]: begin
        cls.is_digit = 1'b1;
        cls.value    = ch[3:0] + 4'd9;
      end
      CharSpace, CharTab, CharComma, CharColon, CharDash: begin
        cls.is_sep = 1'b1;
      end
      default: begin
        cls = '0;
      end
    endcase
  end

endmodule

`default_nettype wire

FILE: rtl/hex_text_to_byte_decoder.sv
// Hex text to byte decoder.
// Input channel: one ASCII character per word (text_char) with end_of_text
// marking the last character of a text. Hex digits of either case are paired
// high nibble first; space, tab, comma, colon and dash are skipped.
// Output channel: a byte word (is_status = 0) for every completed pair, and
// one status word (is_status = 1) closing each text with status_code and
// byte_count. An error is sticky for the rest of the text and shows only in
// the status word; bytes of a text that ends in error are void.
// Timing: a character is registered on acceptance and decoded into the
// result register once that register is free, where its first result is
// shown on the output. One character per cycle is sustained while each
// gives at most one result and out_stall stays low; a character that gives
// a byte and a status puts the byte word out first and the status word
// after it, through the single output port.
// Stall: out_stall holds the current result word; in_stall rises once the
// result register cannot drain in time, no words are dropped.
// Reset: rst (synchronous) empties both stages, clears the pairing state and
// sets the byte limit to 256. cfg_wr_en writes the byte limit; the user must
// assert it only while the block is idle, which the block does not enforce.
`default_nettype none

module hex_text_to_byte_decoder (
  input  wire logic       clk,
  input  wire logic       rst,
  input  wire logic       cfg_wr_en,
  input  wire logic [8:0] cfg_wr_data,
  input  wire logic       in_valid,
  output logic            in_stall,
  input  wire logic [7:0] text_char,
  input  wire logic       end_of_text,
  output logic            out_valid,
  input  wire logic       out_stall,
  output logic            is_status,
  output logic [7:0]      data_byte,
  output logic [1:0]      status_code,
  output logic [8:0]      byte_count,
  output logic            run_end
);

  localparam logic [8:0] BufCap =
    (hexdec_pkg::BufferBytes > 511) ? 9'd511 : 9'(hexdec_pkg::BufferBytes);

  logic [8:0] byte_limit;
  logic [8:0] limit;

  // input register
  logic       s1_valid;
  logic [7:0] s1_char;
  logic       s1_eot;

  // pairing state
  logic             nibble_pending, nibble_pending_next;
  logic [3:0]       held_nibble, held_nibble_next;
  logic [8:0]       bytes_done, bytes_done_next;
  hexdec_pkg::err_t error_seen, error_seen_next;

  // result register: a byte slot and a status slot
  logic             byte_valid;
  logic [7:0]       byte_data;
  logic             byte_run_end;
  logic             status_valid;
  hexdec_pkg::err_t status_err;
  logic [8:0]       status_count;

  logic             emit_byte;
  logic [7:0]       new_byte;
  hexdec_pkg::err_t err_mid;
  logic             pend_mid;
  logic [8:0]       count_mid;

  hexdec_pkg::char_class_t cls;

  logic can_take;
  logic s1_go;
  logic out_take;

  hexdec_classify u_classify (
    .ch  (s1_char),
    .cls (cls)
  );

  assign limit = (byte_limit < BufCap) ? byte_limit : BufCap;

  assign out_valid = byte_valid | status_valid;
  assign out_take  = out_valid & ~out_stall;
  // result register is free after this edge
  assign can_take  = ~(byte_valid & status_valid) & (~out_valid | ~out_stall);
  assign s1_go     = s1_valid & can_take;
  assign in_stall  = s1_valid & ~can_take;

  assign is_status   = ~byte_valid;
  assign data_byte   = byte_valid ? byte_data : 8'd0;
  assign status_code = byte_valid ? 2'd0 : status_err;
  assign byte_count  = byte_valid ? 9'd0 : status_count;
  assign run_end     = byte_valid ? byte_run_end : 1'b1;

  always_comb begin
    err_mid             = error_seen;
    pend_mid            = nibble_pending;
    count_mid           = bytes_done;
    held_nibble_next    = held_nibble;
    emit_byte           = 1'b0;
    new_byte            = {held_nibble, cls.value};
    if (error_seen == hexdec_pkg::ErrNone) begin
      if (!cls.is_digit) begin
        if (!cls.is_sep) begin
          err_mid = hexdec_pkg::ErrBadChar;
        end
      end else if (!nibble_pending) begin
        held_nibble_next = cls.value;
        pend_mid         = 1'b1;
      end else if (bytes_done >= limit) begin
        err_mid = hexdec_pkg::ErrOverflow;
      end else begin
        emit_byte = 1'b1;
        count_mid = bytes_done + 9'd1;
        pend_mid  = 1'b0;
      end
    end
    if (s1_eot && err_mid == hexdec_pkg::ErrNone && pend_mid) begin
      err_mid = hexdec_pkg::ErrOdd;
    end
    // text closes: drop back to the reset state
    if (s1_eot) begin
      error_seen_next     = hexdec_pkg::ErrNone;
      nibble_pending_next = 1'b0;
      held_nibble_next    = 4'd0;
      bytes_done_next     = 9'd0;
    end else begin
      error_seen_next     = err_mid;
      nibble_pending_next = pend_mid;
      bytes_done_next     = count_mid;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_limit <= 9'd256;
    end else if (cfg_wr_en) begin
      byte_limit <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_valid && !in_stall) begin
      s1_valid <= 1'b1;
    end else if (s1_go) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && !in_stall) begin
      s1_char <= text_char;
      s1_eot  <= end_of_text;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      nibble_pending <= 1'b0;
      held_nibble    <= 4'd0;
      bytes_done     <= 9'd0;
      error_seen     <= hexdec_pkg::ErrNone;
    end else if (s1_go) begin
      nibble_pending <= nibble_pending_next;
      held_nibble    <= held_nibble_next;
      bytes_done     <= bytes_done_next;
      error_seen     <= error_seen_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_valid   <= 1'b0;
      status_valid <= 1'b0;
    end else if (s1_go) begin
      byte_valid   <= emit_byte;
      status_valid <= s1_eot;
    end else if (out_take) begin
      // byte word goes first when both slots are full
      if (byte_valid) begin
        byte_valid <= 1'b0;
      end else begin
        status_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s1_go) begin
      byte_data    <= new_byte;
      byte_run_end <= ~s1_eot;
      status_err   <= err_mid;
      status_count <= count_mid;
    end
  end

endmodule

`default_nettype wire

FILE: rtl/hexdec_checker.sv
`default_nettype none

module hexdec_checker (
  input wire logic       clk,
  input wire logic       rst,
  input wire logic       out_valid,
  input wire logic       out_stall,
  input wire logic       is_status,
  input wire logic [7:0] data_byte,
  input wire logic [1:0] status_code,
  input wire logic [8:0] byte_count,
  input wire logic       run_end
);

  // nothing leaves the block in the cycle after reset
  a_reset_empty: assert property (@(posedge clk) rst |=> !out_valid)
    else $error("result word valid right after reset");

  // a byte word that does not close its character is followed by the status
  a_status_follows: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_stall && !is_status && !run_end |=> out_valid && is_status)
    else $error("status word missing after a non-final byte word");

  // status words close the text with a clean byte field and a bounded count
  a_status_shape: assert property (@(posedge clk) disable iff (rst)
    out_valid && is_status |-> run_end && data_byte == 8'd0 && byte_count <= 9'd256)
    else $error("malformed status word");

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(is_status) && $stable(data_byte)
      && $stable(status_code) && $stable(byte_count) && $stable(run_end))
    else $error("stalled result word changed");

endmodule

bind hex_text_to_byte_decoder hexdec_checker u_hexdec_checker (
  .clk         (clk),
  .rst         (rst),
  .out_valid   (out_valid),
  .out_stall   (out_stall),
  .is_status   (is_status),
  .data_byte   (data_byte),
  .status_code (status_code),
  .byte_count  (byte_count),
  .run_end     (run_end)
);

`default_nettype wire
